// ----- rtl/core/mcps_pkg.sv -----
// shared types and constants for the modbus channel poll scheduler
package mcps_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  localparam int ACT_W    = 3;
  localparam int SLAVE_W  = 8;
  localparam int TYPE_W   = 2;
  localparam int ADDR_W   = 16;
  localparam int CH_W     = 8;
  localparam int DATA_W   = 16;
  localparam int TIME_W   = 32;

  localparam logic [TIME_W-1:0] PERIOD_RST = 32'd1000;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 3'd0,
    ACT_POLL  = 3'd1,
    ACT_READ  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_REPLY = 3'd4
  } action_t;

  typedef enum logic [TYPE_W-1:0] {
    REG_COIL     = 2'd0,
    REG_DISCRETE = 2'd1,
    REG_HOLDING  = 2'd2,
    REG_INPUT    = 2'd3
  } reg_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_init;
    logic scan_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic poll_go;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/mcps_ctrl.sv -----
// controller state machine for the poll scheduler
module mcps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  mcps_pkg::sts_t sts,
  output mcps_pkg::cmd_t cmd,
  output logic          in_stall
);

  mcps_pkg::state_t state_r;
  mcps_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcps_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mcps_pkg::ST_EXEC;
      end
      mcps_pkg::ST_EXEC: begin
        state_nxt = sts.poll_go ? mcps_pkg::ST_SCAN : mcps_pkg::ST_RESULT;
      end
      mcps_pkg::ST_SCAN: begin
        if (sts.hit || sts.last) state_nxt = mcps_pkg::ST_RESULT;
      end
      mcps_pkg::ST_RESULT: begin
        if (sts.out_free) state_nxt = mcps_pkg::ST_IDLE;
      end
      default: state_nxt = mcps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      mcps_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      mcps_pkg::ST_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.scan_init = sts.poll_go;
      end
      mcps_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      mcps_pkg::ST_RESULT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/core/mcps_dp.sv -----
// datapath: channel table, scan pointer, period register and result registers
module mcps_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mcps_pkg::cmd_t               cmd,
  output mcps_pkg::sts_t               sts,
  input  logic                         cfg_wr_en,
  input  logic [mcps_pkg::TIME_W-1:0]  cfg_wr_data,
  input  logic [mcps_pkg::ACT_W-1:0]   in_action,
  input  logic [mcps_pkg::SLAVE_W-1:0] in_slave_addr,
  input  logic [mcps_pkg::TYPE_W-1:0]  in_reg_type,
  input  logic [mcps_pkg::ADDR_W-1:0]  in_reg_addr,
  input  logic [mcps_pkg::CH_W-1:0]    in_channel,
  input  logic [mcps_pkg::DATA_W-1:0]  in_value,
  input  logic [mcps_pkg::TIME_W-1:0]  in_now_ms,
  input  logic                         in_master_busy,
  input  logic                         in_master_accepts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_request_valid,
  output logic [mcps_pkg::SLAVE_W-1:0] out_req_slave_addr,
  output logic [mcps_pkg::TYPE_W-1:0]  out_req_reg_type,
  output logic [mcps_pkg::ADDR_W-1:0]  out_req_reg_addr,
  output logic [mcps_pkg::CH_W-1:0]    out_req_channel,
  output logic [mcps_pkg::DATA_W-1:0]  out_read_data
);

  localparam int N     = mcps_pkg::MAX_CHANNELS;
  localparam int IDX_W = mcps_pkg::IDX_W;
  localparam int CNT_W = mcps_pkg::CNT_W;
  localparam logic [mcps_pkg::TIME_W-1:0] PERIOD_RST_W = mcps_pkg::PERIOD_RST;

  // channel table
  logic [mcps_pkg::SLAVE_W-1:0] tbl_slave_r [N];
  logic [mcps_pkg::TYPE_W-1:0]  tbl_type_r  [N];
  logic [mcps_pkg::ADDR_W-1:0]  tbl_addr_r  [N];
  logic [mcps_pkg::DATA_W-1:0]  tbl_data_r  [N];
  logic [mcps_pkg::TIME_W-1:0]  tbl_last_r  [N];

  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] ptr_r;
  logic [mcps_pkg::TIME_W-1:0] period_r;

  // captured item
  logic [mcps_pkg::ACT_W-1:0]   act_r;
  logic [mcps_pkg::SLAVE_W-1:0] slave_r;
  logic [mcps_pkg::TYPE_W-1:0]  type_r;
  logic [mcps_pkg::ADDR_W-1:0]  addr_r;
  logic [mcps_pkg::CH_W-1:0]    ch_r;
  logic [mcps_pkg::DATA_W-1:0]  value_r;
  logic [mcps_pkg::TIME_W-1:0]  now_r;
  logic                         busy_r;
  logic                         accepts_r;

  // scan state
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] scan_cnt_r;

  // result under construction
  logic                         res_req_r;
  logic [mcps_pkg::SLAVE_W-1:0] res_slave_r;
  logic [mcps_pkg::TYPE_W-1:0]  res_type_r;
  logic [mcps_pkg::ADDR_W-1:0]  res_addr_r;
  logic [mcps_pkg::CH_W-1:0]    res_ch_r;
  logic [mcps_pkg::DATA_W-1:0]  res_data_r;

  // output register
  logic                         out_valid_r;
  logic                         out_req_r;
  logic [mcps_pkg::SLAVE_W-1:0] out_slave_r;
  logic [mcps_pkg::TYPE_W-1:0]  out_type_r;
  logic [mcps_pkg::ADDR_W-1:0]  out_addr_r;
  logic [mcps_pkg::CH_W-1:0]    out_ch_r;
  logic [mcps_pkg::DATA_W-1:0]  out_data_r;

  logic                         ch_ok;
  logic                         full;
  logic [IDX_W-1:0]             rd_idx;
  logic [mcps_pkg::TYPE_W-1:0]  rd_type;
  logic [mcps_pkg::DATA_W-1:0]  rd_data;
  logic [mcps_pkg::TIME_W-1:0]  elapsed;
  logic                         hit;
  logic                         idx_wraps;
  logic [IDX_W-1:0]             idx_next;
  logic                         add_we;
  logic                         data_we;
  logic [IDX_W-1:0]             data_waddr;
  logic [mcps_pkg::DATA_W-1:0]  data_wdata;
  logic                         last_we;
  logic [IDX_W-1:0]             last_waddr;
  logic [IDX_W-1:0]             add_idx;

  assign full    = (count_r == CNT_W'(N));
  assign ch_ok   = (ch_r < mcps_pkg::CH_W'(count_r));
  assign add_idx = count_r[IDX_W-1:0];

  // single read port shared by the scan and indexed accesses
  assign rd_idx  = cmd.scan_step ? scan_idx_r : ch_r[IDX_W-1:0];
  assign rd_type = tbl_type_r[rd_idx];
  assign rd_data = tbl_data_r[rd_idx];
  assign elapsed = now_r - tbl_last_r[rd_idx];
  assign hit     = (elapsed >= period_r);

  assign idx_wraps = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);
  assign idx_next  = idx_wraps ? '0 : scan_idx_r + IDX_W'(1);

  always_comb begin
    add_we     = cmd.exec && (act_r == mcps_pkg::ACT_ADD) && !full;
    data_we    = 1'b0;
    data_waddr = ch_r[IDX_W-1:0];
    data_wdata = value_r;
    if (add_we) begin
      data_we    = 1'b1;
      data_waddr = add_idx;
      data_wdata = '0;
    end else if (cmd.exec && ch_ok && (act_r == mcps_pkg::ACT_REPLY)) begin
      data_we = 1'b1;
    end else if (cmd.exec && ch_ok && (act_r == mcps_pkg::ACT_WRITE)) begin
      if (rd_type == mcps_pkg::REG_COIL) begin
        data_we    = 1'b1;
        data_wdata = (value_r != '0) ? mcps_pkg::DATA_W'(1) : '0;
      end else if (rd_type == mcps_pkg::REG_DISCRETE) begin
        data_we = 1'b1;
      end
    end
    last_we    = add_we || (cmd.scan_step && hit);
    last_waddr = add_we ? add_idx : scan_idx_r;
  end

  always_ff @(posedge clk) begin
    if (add_we) begin
      tbl_slave_r[add_idx] <= slave_r;
      tbl_type_r[add_idx]  <= type_r;
      tbl_addr_r[add_idx]  <= addr_r;
    end
    if (data_we) tbl_data_r[data_waddr] <= data_wdata;
    if (last_we) tbl_last_r[last_waddr] <= now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ptr_r    <= '0;
      period_r <= PERIOD_RST_W;
    end else begin
      if (cfg_wr_en) period_r <= cfg_wr_data;
      if (add_we) count_r <= count_r + CNT_W'(1);
      if (cmd.scan_step && hit) ptr_r <= idx_next;
    end
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r     <= in_action;
      slave_r   <= in_slave_addr;
      type_r    <= in_reg_type;
      addr_r    <= in_reg_addr;
      ch_r      <= in_channel;
      value_r   <= in_value;
      now_r     <= in_now_ms;
      busy_r    <= in_master_busy;
      accepts_r <= in_master_accepts;
    end
    if (cmd.scan_init) begin
      scan_idx_r <= ptr_r;
      scan_cnt_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= idx_next;
      scan_cnt_r <= scan_cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_req_r   <= 1'b0;
      res_slave_r <= '0;
      res_type_r  <= '0;
      res_addr_r  <= '0;
      res_ch_r    <= '0;
      res_data_r  <= '0;
    end else if (cmd.exec && ch_ok && (act_r == mcps_pkg::ACT_READ)) begin
      res_data_r <= rd_data;
    end else if (cmd.scan_step && hit) begin
      res_req_r   <= 1'b1;
      res_slave_r <= tbl_slave_r[rd_idx];
      res_type_r  <= rd_type;
      res_addr_r  <= tbl_addr_r[rd_idx];
      res_ch_r    <= mcps_pkg::CH_W'(scan_idx_r);
    end
  end

  // output register, freed by a transfer on the result side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_req_r   <= res_req_r;
      out_slave_r <= res_slave_r;
      out_type_r  <= res_type_r;
      out_addr_r  <= res_addr_r;
      out_ch_r    <= res_ch_r;
      out_data_r  <= res_data_r;
    end
  end

  assign sts.poll_go  = (act_r == mcps_pkg::ACT_POLL) && !busy_r && accepts_r &&
                        (count_r != '0);
  assign sts.hit      = hit;
  assign sts.last     = ((CNT_W'(scan_cnt_r) + CNT_W'(1)) == count_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_request_valid  = out_req_r;
  assign out_req_slave_addr = out_slave_r;
  assign out_req_reg_type   = out_type_r;
  assign out_req_reg_addr   = out_addr_r;
  assign out_req_channel    = out_ch_r;
  assign out_read_data      = out_data_r;

endmodule

// ----- rtl/core/modbus_channel_poll_scheduler.sv -----
// top level of the round robin modbus channel poll scheduler
//
// input channel: in_valid / in_stall carry one action (add, poll tick, read,
// write, reply) with all of its fields. output channel: out_valid / out_stall
// carry exactly one result per accepted action.
// cfg_wr_en / cfg_wr_data write the poll period in milliseconds (reset 1000).
// one action is worked on at a time: in_stall is high from the transfer until
// its result is loaded into the output register.
// add, read, write, reply and a poll tick that scans nothing go from the
// execute state straight to the result state; out_valid rises once the
// result is loaded into the output register. a scanning poll tick walks the
// table one entry per cycle through the single table read port, up to and
// including the first entry due (at most the entry count, 16).
// the output register lets the next action transfer while a result waits;
// a stalled receiver holds the result and, once a second result is ready,
// holds the input side too.
// synchronous reset empties the table, clears the round robin pointer and the
// output register and restores the period.
module modbus_channel_poll_scheduler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mcps_pkg::TIME_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mcps_pkg::ACT_W-1:0]   in_action,
  input  logic [mcps_pkg::SLAVE_W-1:0] in_slave_addr,
  input  logic [mcps_pkg::TYPE_W-1:0]  in_reg_type,
  input  logic [mcps_pkg::ADDR_W-1:0]  in_reg_addr,
  input  logic [mcps_pkg::CH_W-1:0]    in_channel,
  input  logic [mcps_pkg::DATA_W-1:0]  in_value,
  input  logic [mcps_pkg::TIME_W-1:0]  in_now_ms,
  input  logic                         in_master_busy,
  input  logic                         in_master_accepts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_request_valid,
  output logic [mcps_pkg::SLAVE_W-1:0] out_req_slave_addr,
  output logic [mcps_pkg::TYPE_W-1:0]  out_req_reg_type,
  output logic [mcps_pkg::ADDR_W-1:0]  out_req_reg_addr,
  output logic [mcps_pkg::CH_W-1:0]    out_req_channel,
  output logic [mcps_pkg::DATA_W-1:0]  out_read_data
);

  mcps_pkg::cmd_t cmd;
  mcps_pkg::sts_t sts;

  mcps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  mcps_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_action          (in_action),
    .in_slave_addr      (in_slave_addr),
    .in_reg_type        (in_reg_type),
    .in_reg_addr        (in_reg_addr),
    .in_channel         (in_channel),
    .in_value           (in_value),
    .in_now_ms          (in_now_ms),
    .in_master_busy     (in_master_busy),
    .in_master_accepts  (in_master_accepts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_request_valid  (out_request_valid),
    .out_req_slave_addr (out_req_slave_addr),
    .out_req_reg_type   (out_req_reg_type),
    .out_req_reg_addr   (out_req_reg_addr),
    .out_req_channel    (out_req_channel),
    .out_read_data      (out_read_data)
  );

endmodule

// ----- rtl/core/mcps_chk.sv -----
// port level checker for the poll scheduler, bound to the top level
module mcps_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_request_valid,
  input logic [mcps_pkg::SLAVE_W-1:0] out_req_slave_addr,
  input logic [mcps_pkg::TYPE_W-1:0]  out_req_reg_type,
  input logic [mcps_pkg::ADDR_W-1:0]  out_req_reg_addr,
  input logic [mcps_pkg::CH_W-1:0]    out_req_channel,
  input logic [mcps_pkg::DATA_W-1:0]  out_read_data
);

  // no request means all request fields are zero
  a_req_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_request_valid) |->
      (out_req_slave_addr == '0 && out_req_reg_type == '0 &&
       out_req_reg_addr == '0 && out_req_channel == '0))
    else $error("request fields set without a request");

  // a read result and a request never share one transfer
  a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_data != '0) |-> !out_request_valid)
    else $error("read data alongside a request");

  // one action at a time: input stalls right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_data) &&
      $stable(out_request_valid) && $stable(out_req_channel)))
    else $error("stalled result changed");

endmodule

bind modbus_channel_poll_scheduler mcps_chk u_mcps_chk (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the modbus channel poll scheduler
module tb;

  localparam logic [mcps_pkg::ACT_W-1:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [mcps_pkg::ACT_W-1:0] ACT_UNDEF_HI = 3'd7;
  localparam logic [mcps_pkg::TIME_W-1:0] T0 = 32'hFFFF_FC00;

  typedef struct packed {
    logic [mcps_pkg::ACT_W-1:0]   action;
    logic [mcps_pkg::SLAVE_W-1:0] slave_addr;
    logic [mcps_pkg::TYPE_W-1:0]  reg_type;
    logic [mcps_pkg::ADDR_W-1:0]  reg_addr;
    logic [mcps_pkg::CH_W-1:0]    channel;
    logic [mcps_pkg::DATA_W-1:0]  value;
    logic [mcps_pkg::TIME_W-1:0]  now_ms;
    logic                         master_busy;
    logic                         master_accepts;
  } poll_action_t;

  typedef struct packed {
    logic                         req_valid;
    logic [mcps_pkg::SLAVE_W-1:0] slave;
    logic [mcps_pkg::TYPE_W-1:0]  rtype;
    logic [mcps_pkg::ADDR_W-1:0]  raddr;
    logic [mcps_pkg::CH_W-1:0]    chan;
    logic [mcps_pkg::DATA_W-1:0]  rdata;
  } poll_result_t;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BLOCKED} rx_mode_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [mcps_pkg::TIME_W-1:0]  cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [mcps_pkg::ACT_W-1:0]   in_action = '0;
  logic [mcps_pkg::SLAVE_W-1:0] in_slave_addr = '0;
  logic [mcps_pkg::TYPE_W-1:0]  in_reg_type = '0;
  logic [mcps_pkg::ADDR_W-1:0]  in_reg_addr = '0;
  logic [mcps_pkg::CH_W-1:0]    in_channel = '0;
  logic [mcps_pkg::DATA_W-1:0]  in_value = '0;
  logic [mcps_pkg::TIME_W-1:0]  in_now_ms = '0;
  logic                         in_master_busy = 1'b0;
  logic                         in_master_accepts = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_request_valid;
  logic [mcps_pkg::SLAVE_W-1:0] out_req_slave_addr;
  logic [mcps_pkg::TYPE_W-1:0]  out_req_reg_type;
  logic [mcps_pkg::ADDR_W-1:0]  out_req_reg_addr;
  logic [mcps_pkg::CH_W-1:0]    out_req_channel;
  logic [mcps_pkg::DATA_W-1:0]  out_read_data;

  // predicted scheduler state
  logic [mcps_pkg::SLAVE_W-1:0] tbl_slave [mcps_pkg::MAX_CHANNELS];
  logic [mcps_pkg::TYPE_W-1:0]  tbl_type  [mcps_pkg::MAX_CHANNELS];
  logic [mcps_pkg::ADDR_W-1:0]  tbl_addr  [mcps_pkg::MAX_CHANNELS];
  logic [mcps_pkg::DATA_W-1:0]  tbl_data  [mcps_pkg::MAX_CHANNELS];
  logic [mcps_pkg::TIME_W-1:0]  tbl_stamp [mcps_pkg::MAX_CHANNELS];
  int                           tbl_count;
  int                           rr_ptr;
  logic [mcps_pkg::TIME_W-1:0]  period_ms;

  poll_action_t pending_actions[$];
  poll_result_t expected_results[$];
  poll_action_t cur_action;
  poll_result_t want;
  logic [mcps_pkg::TIME_W-1:0] t_ms;
  int gap_left, burst_left, rx_left;
  rx_mode_t rx_mode;
  int errors, actions_sent, results_checked, requests_seen, periods_used;

  always #10 clk = ~clk;

  modbus_channel_poll_scheduler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_slave_addr     (in_slave_addr),
    .in_reg_type       (in_reg_type),
    .in_reg_addr       (in_reg_addr),
    .in_channel        (in_channel),
    .in_value          (in_value),
    .in_now_ms         (in_now_ms),
    .in_master_busy    (in_master_busy),
    .in_master_accepts (in_master_accepts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_request_valid (out_request_valid),
    .out_req_slave_addr(out_req_slave_addr),
    .out_req_reg_type  (out_req_reg_type),
    .out_req_reg_addr  (out_req_reg_addr),
    .out_req_channel   (out_req_channel),
    .out_read_data     (out_read_data)
  );

  function automatic poll_result_t schedule_action(poll_action_t a);
    poll_result_t r;
    int k;
    logic [mcps_pkg::TIME_W-1:0] elapsed;
    logic found;
    r = '0;
    found = 1'b0;
    case (a.action)
      mcps_pkg::ACT_ADD: if (tbl_count < mcps_pkg::MAX_CHANNELS) begin
        tbl_slave[tbl_count] = a.slave_addr;
        tbl_type[tbl_count]  = a.reg_type;
        tbl_addr[tbl_count]  = a.reg_addr;
        tbl_data[tbl_count]  = '0;
        tbl_stamp[tbl_count] = a.now_ms;
        tbl_count++;
      end
      mcps_pkg::ACT_POLL: if (!a.master_busy && tbl_count != 0 && a.master_accepts) begin
        for (int i = 0; i < tbl_count; i++) begin
          k = (rr_ptr + i) % tbl_count;
          elapsed = a.now_ms - tbl_stamp[k];
          if (!found && elapsed >= period_ms) begin
            found = 1'b1;
            r.req_valid = 1'b1;
            r.slave = tbl_slave[k];
            r.rtype = tbl_type[k];
            r.raddr = tbl_addr[k];
            r.chan = mcps_pkg::CH_W'(k);
            tbl_stamp[k] = a.now_ms;
            rr_ptr = (k + 1) % tbl_count;
          end
        end
      end
      mcps_pkg::ACT_READ: if (a.channel < tbl_count) begin
        r.rdata = tbl_data[a.channel];
      end
      mcps_pkg::ACT_WRITE: if (a.channel < tbl_count) begin
        if (tbl_type[a.channel] == mcps_pkg::REG_COIL) begin
          tbl_data[a.channel] = (a.value != 0) ? mcps_pkg::DATA_W'(1) : '0;
        end else if (tbl_type[a.channel] == mcps_pkg::REG_DISCRETE) begin
          tbl_data[a.channel] = a.value;
        end
      end
      mcps_pkg::ACT_REPLY: if (a.channel < tbl_count) begin
        tbl_data[a.channel] = a.value;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(schedule_action(cur_action));
        actions_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_actions.size() > 0) begin
          cur_action = pending_actions.pop_front();
          in_valid          <= 1'b1;
          in_action         <= cur_action.action;
          in_slave_addr     <= cur_action.slave_addr;
          in_reg_type       <= cur_action.reg_type;
          in_reg_addr       <= cur_action.reg_addr;
          in_channel        <= cur_action.channel;
          in_value          <= cur_action.value;
          in_now_ms         <= cur_action.now_ms;
          in_master_busy    <= cur_action.master_busy;
          in_master_accepts <= cur_action.master_accepts;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 3);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, switching between modes of different pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 60);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
        RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
        default:  out_stall <= ($urandom_range(0, 99) < 95);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("request_valid", want.req_valid, out_request_valid);
        compare_field("req_slave_addr", want.slave, out_req_slave_addr);
        compare_field("req_reg_type", want.rtype, out_req_reg_type);
        compare_field("req_reg_addr", want.raddr, out_req_reg_addr);
        compare_field("req_channel", want.chan, out_req_channel);
        compare_field("read_data", want.rdata, out_read_data);
        results_checked++;
        if (out_request_valid) requests_seen++;
      end
    end
  end

  task automatic queue_action(logic [mcps_pkg::ACT_W-1:0] act,
                              logic [mcps_pkg::SLAVE_W-1:0] sa,
                              logic [mcps_pkg::TYPE_W-1:0] rt,
                              logic [mcps_pkg::ADDR_W-1:0] ra,
                              logic [mcps_pkg::CH_W-1:0] ch,
                              logic [mcps_pkg::DATA_W-1:0] val,
                              logic [mcps_pkg::TIME_W-1:0] now, logic busy, logic acc);
    poll_action_t a;
    a = '{act, sa, rt, ra, ch, val, now, busy, acc};
    pending_actions.push_back(a);
  endtask

  // mostly time-ordered traffic, with some arbitrary timestamps as noise
  task automatic queue_random(int n, logic [mcps_pkg::TIME_W-1:0] span, int add_pct);
    poll_action_t a;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) a.action = mcps_pkg::ACT_ADD;
      else if (r < add_pct + 45) a.action = mcps_pkg::ACT_POLL;
      else if (r < add_pct + 60) a.action = mcps_pkg::ACT_READ;
      else if (r < add_pct + 74) a.action = mcps_pkg::ACT_WRITE;
      else if (r < add_pct + 88) a.action = mcps_pkg::ACT_REPLY;
      else if (r < add_pct + 92)
        a.action = mcps_pkg::ACT_W'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
      else a.action = mcps_pkg::ACT_POLL;
      a.slave_addr = mcps_pkg::SLAVE_W'($urandom);
      a.reg_type = mcps_pkg::TYPE_W'($urandom_range(mcps_pkg::REG_INPUT, mcps_pkg::REG_COIL));
      a.reg_addr = mcps_pkg::ADDR_W'($urandom);
      a.channel = ($urandom_range(0, 99) < 85) ? mcps_pkg::CH_W'($urandom_range(0, 17))
                                               : mcps_pkg::CH_W'($urandom);
      a.value = ($urandom_range(0, 9) == 0) ? '0 : mcps_pkg::DATA_W'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        t_ms = t_ms + $urandom_range(0, span);
        a.now_ms = t_ms;
      end else begin
        a.now_ms = $urandom;
      end
      a.master_busy = ($urandom_range(0, 99) < 15);
      a.master_accepts = ($urandom_range(0, 99) < 85);
      pending_actions.push_back(a);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_actions.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (25) @(posedge clk);
  endtask

  task automatic set_period(logic [mcps_pkg::TIME_W-1:0] p);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    period_ms = p;
    periods_used++;
    @(posedge clk);
  endtask

  initial begin
    tbl_count = 0;
    rr_ptr = 0;
    period_ms = mcps_pkg::PERIOD_RST;
    periods_used = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, undefined codes
    queue_action(mcps_pkg::ACT_POLL, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0000, T0, 1'b0, 1'b1);
    queue_action(mcps_pkg::ACT_READ, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0000, 32'h0, 1'b0, 1'b0);
    queue_action(ACT_UNDEF_LO, 8'hFF, mcps_pkg::REG_INPUT, 16'hFFFF, 8'hFF,
                 16'hFFFF, '1, 1'b1, 1'b1);
    queue_action(ACT_UNDEF_HI, 8'hFF, mcps_pkg::REG_INPUT, 16'hFFFF, 8'hFF,
                 16'hFFFF, '1, 1'b1, 1'b1);
    // one entry of each register type
    queue_action(mcps_pkg::ACT_ADD, 8'hFF, mcps_pkg::REG_INPUT, 16'hFFFF, 8'hFF,
                 16'hFFFF, T0, 1'b1, 1'b1);
    queue_action(mcps_pkg::ACT_ADD, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0000, T0 + 10, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_ADD, 8'h5A, mcps_pkg::REG_DISCRETE, 16'h1234, 8'h00,
                 16'h0000, T0 + 20, 1'b0, 1'b1);
    queue_action(mcps_pkg::ACT_ADD, 8'hA5, mcps_pkg::REG_HOLDING, 16'h8000, 8'h00,
                 16'h0000, T0 + 30, 1'b0, 1'b1);
    // busy, refused, not yet due, then due (second one across the time wrap)
    queue_action(mcps_pkg::ACT_POLL, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0000, T0 + 5000, 1'b1, 1'b1);
    queue_action(mcps_pkg::ACT_POLL, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0000, T0 + 5000, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_POLL, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0000, T0 + 999, 1'b0, 1'b1);
    queue_action(mcps_pkg::ACT_POLL, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0000, T0 + 1000, 1'b0, 1'b1);
    queue_action(mcps_pkg::ACT_POLL, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0000, T0 + 1500, 1'b0, 1'b1);
    // data word access per register type
    queue_action(mcps_pkg::ACT_WRITE, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h01,
                 16'h0002, 32'h0, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_READ, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h01,
                 16'h0000, 32'h0, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_WRITE, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h02,
                 16'hA5A5, 32'h0, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_READ, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h02,
                 16'h0000, 32'h0, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_WRITE, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h03,
                 16'hFFFF, 32'h0, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_REPLY, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h03,
                 16'hFFFF, 32'h0, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_READ, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h03,
                 16'h0000, 32'h0, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_WRITE, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0001, 32'h0, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_READ, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0000, 32'h0, 1'b0, 1'b0);
    // out of range channel
    queue_action(mcps_pkg::ACT_READ, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'hFF,
                 16'h0000, 32'h0, 1'b0, 1'b0);
    queue_action(mcps_pkg::ACT_WRITE, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h04,
                 16'h7777, 32'h0, 1'b0, 1'b0);

    t_ms = T0 + 1500;
    queue_random(120, 400, 0);
    wait_idle();

    // longest period: only a full-range elapsed time is due
    set_period('1);
    queue_action(mcps_pkg::ACT_ADD, 8'h3C, mcps_pkg::REG_DISCRETE, 16'h00FF, 8'h00,
                 16'h0000, t_ms, 1'b0, 1'b1);
    queue_action(mcps_pkg::ACT_POLL, 8'h00, mcps_pkg::REG_COIL, 16'h0000, 8'h00,
                 16'h0000, t_ms - 1, 1'b0, 1'b1);
    queue_random(110, 5000, 5);
    wait_idle();

    // zero period: every entry is always due
    set_period('0);
    queue_random(140, 3, 6);
    wait_idle();

    set_period(32'd7);
    queue_random(140, 8, 5);
    wait_idle();

    set_period(mcps_pkg::TIME_W'($urandom_range(1, 3000)));
    queue_random(140, period_ms / 2 + 1, 3);
    wait_idle();

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("covered %0d actions, %0d results checked, %0d read requests issued",
             actions_sent, results_checked, requests_seen);
    $display("across %0d poll periods, table ended with %0d of %0d channels",
             periods_used, tbl_count, mcps_pkg::MAX_CHANNELS);
    if (errors == 0) begin
      $display("modbus_channel_poll_scheduler test passed");
    end else begin
      $display("modbus_channel_poll_scheduler test failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $error("timeout with %0d actions pending and %0d results outstanding",
           pending_actions.size(), expected_results.size());
    $display("modbus_channel_poll_scheduler test failed");
    $finish;
  end

endmodule
